[rtl/core/gaussian_blur_stencil_assert.svh]
// assertion macros for the gaussian blur stencil
// used by the top level; needs a clock and an active-low reset in scope
`ifndef GAUSSIAN_BLUR_STENCIL_ASSERT_SVH
`define GAUSSIAN_BLUR_STENCIL_ASSERT_SVH

// same-cycle implication
`define GBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define GBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/gbs_pkg.sv]
// package for the gaussian blur stencil
// shared constants, types and state encoding; no dependencies
package gbs_pkg;

  localparam int DEF_RADIUS    = 5;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int PIX_W         = 8;
  localparam int TAP_W         = 16;
  localparam int NUM_TAPS      = 6;
  localparam int NUM_LANES     = 3;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 16;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_FIRST    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_LAST     = 8'd7;

  localparam logic [10:0]      RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [15:0]      RST_IMAGE_HEIGHT = 16'd1024;
  localparam logic [TAP_W-1:0] RST_TAP [NUM_TAPS] =
    '{16'd5987, 16'd5984, 16'd5975, 16'd5961, 16'd5940, 16'd5914};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_CALC,
    ST_FLUSH,
    ST_EMIT
  } gbs_state_e;

  typedef struct packed {
    logic clear;
    logic valid;
  } gbs_lane_ctrl_t;

endpackage

[rtl/core/gbs_ram.sv]
// generic single-write, single-read ram with registered read
// no dependencies
module gbs_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/gbs_lane.sv]
// one color lane: weight times pixel, then accumulate over the window
// depends on gbs_pkg
module gbs_lane
  import gbs_pkg::*;
#(
  parameter int AccW = 47
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gbs_lane_ctrl_t        ctrl_i,
  input  logic [2*TAP_W-1:0]    weight_i,
  input  logic [PIX_W-1:0]      pix_i,
  output logic [AccW-1:0]       acc_o
);

  logic [2*TAP_W+PIX_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic [AccW-1:0]          acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.valid && !ctrl_i.clear;
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= acc_q + AccW'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= (2*TAP_W+PIX_W)'(weight_i) * (2*TAP_W+PIX_W)'(pix_i);
  end

  assign acc_o = acc_q;

endmodule

[rtl/core/gbs_merge.sv]
// merges the lane sums: scale, saturate and hold in the output register
// depends on gbs_pkg
module gbs_merge
  import gbs_pkg::*;
#(
  parameter int AccW = 47
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic                        last_i,
  input  logic [NUM_LANES*AccW-1:0]   acc_i,
  output logic                        free_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [NUM_LANES*PIX_W-1:0]  data_o,
  output logic                        last_o
);

  logic                       valid_q;
  logic                       last_q;
  logic [NUM_LANES*PIX_W-1:0] data_q;
  logic [NUM_LANES*PIX_W-1:0] data_d;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (acc_i[l*AccW+32 +: AccW-32] > (AccW-32)'(255)) begin
        data_d[l*PIX_W +: PIX_W] = '1;
      end else begin
        data_d[l*PIX_W +: PIX_W] = acc_i[l*AccW+32 +: PIX_W];
      end
    end
  end

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign last_o  = last_q;

endmodule

[rtl/core/gaussian_blur_stencil.sv]
// channel      | dir | handshake                     | content
// s_axis       | in  | s_axis_tvalid / s_axis_tready | tdata red,green,blue; tuser command
// m_axis       | out | m_axis_tvalid / m_axis_tready | tdata red,green,blue; tlast frame_end
// cfg          | in  | cfg_valid_i / cfg_ready_o     | cfg_index_i register, cfg_data_i value
// an item that gives no result is taken in ST_IDLE and the block stays idle; one that gives a
// result runs the window sweep (ST_ROW, then ST_CALC, for each window row), then ST_FLUSH and ST_EMIT,
// the sweep reading one line-store word per cycle in ST_CALC for all three lanes at once
// reset clears control state; the line store needs no clearing
// the output register frees the input side while a result waits downstream
// depends on gbs_pkg, gbs_ram, gbs_lane, gbs_merge and the assertion header
`include "gaussian_blur_stencil_assert.svh"
module gaussian_blur_stencil
  import gbs_pkg::*;
#(
  parameter int RADIUS    = DEF_RADIUS,
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,  // red_in, green_in, blue_in
  input  logic                  s_axis_tuser,  // command
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,  // red_out, green_out, blue_out
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int Ring = 2*RADIUS + 2;
  localparam int Win  = 2*RADIUS + 1;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int FW   = $clog2(MAX_WIDTH + 1);
  localparam int YW   = CW + 2;
  localparam int AW   = $clog2(Ring*MAX_WIDTH);
  localparam int SW   = $clog2(Ring);
  localparam int TW   = $clog2(3*Ring);
  localparam int IW   = $clog2(Win);
  localparam int PW   = $clog2(RADIUS*MAX_WIDTH + RADIUS + 2);
  localparam int AccW = 2*TAP_W + PIX_W + $clog2(Win*Win);

  gbs_state_e state_q, state_d;

  logic [10:0]      width_q;
  logic [15:0]      height_q;
  logic [TAP_W-1:0] tap_q [NUM_TAPS];

  logic          active_q, done_q;
  logic [FW-1:0] fw_q;
  logic [15:0]   fh_q;
  logic [PW-1:0] lag_q, pend_q;
  logic [CW-1:0] in_col_q, out_col_q;
  logic [15:0]   in_row_q, out_row_q;
  logic [SW-1:0] in_slot_q, out_slot_q;
  logic [IW-1:0] win_i_q, win_j_q;

  // cfg port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
      for (int t = 0; t < NUM_TAPS; t++) begin
        tap_q[t] <= RST_TAP[t];
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i[10:0];
      end else if (cfg_index_i == CFG_IMAGE_HEIGHT) begin
        height_q <= cfg_data_i;
      end else if (cfg_index_i >= CFG_TAP_FIRST && cfg_index_i <= CFG_TAP_LAST) begin
        tap_q[3'(cfg_index_i - CFG_TAP_FIRST)] <= cfg_data_i;
      end
    end
  end

  // input side
  logic          in_acc, is_pix, start;
  logic [FW-1:0] fw_e;
  logic [15:0]   fh_e;
  logic [PW-1:0] lag_e, pend_n;
  logic [CW-1:0] col_b;
  logic [15:0]   row_b;
  logic [SW-1:0] slot_b;
  logic          col_wrap, row_end, res_ready;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign is_pix = s_axis_tuser == CMD_PIXEL;
  assign start  = !active_q || done_q;

  always_comb begin
    if (!start) begin
      fw_e = fw_q;
    end else if (width_q == '0) begin
      fw_e = FW'(1);
    end else if (13'(width_q) > 13'(MAX_WIDTH)) begin
      fw_e = FW'(MAX_WIDTH);
    end else begin
      fw_e = FW'(width_q);
    end
    fh_e   = start ? ((height_q == '0) ? 16'd1 : height_q) : fh_q;
    lag_e  = start ? (PW'(RADIUS) * PW'(fw_e) + PW'(RADIUS)) : lag_q;
    col_b  = start ? '0 : in_col_q;
    row_b  = start ? '0 : in_row_q;
    slot_b = start ? '0 : in_slot_q;
    pend_n = (start ? '0 : pend_q) + PW'(1);
    col_wrap  = ((CW+1)'(col_b) + (CW+1)'(1)) >= (CW+1)'(fw_e);
    row_end   = col_wrap && ((17'(row_b) + 17'd1) >= 17'(fh_e));
    res_ready = is_pix ? (row_end || pend_n > lag_e) : (active_q && done_q);
  end

  // window sweep
  logic [16:0]    xr;
  logic [YW-1:0]  yc;
  logic           row_ok, col_ok;
  logic [TW-1:0]  slot_t;
  logic [SW-1:0]  rslot;
  logic [AW-1:0]  raddr;
  logic [IW-1:0]  tr, tc;
  logic [2:0]     tap_idx;
  logic [TAP_W-1:0] tap_rd;
  logic           row_last, win_last;

  always_comb begin
    xr     = 17'(out_row_q) + 17'(win_i_q);
    row_ok = xr >= 17'(RADIUS) && xr < (17'(fh_q) + 17'(RADIUS));
    yc     = YW'(out_col_q) + YW'(win_j_q);
    col_ok = yc >= YW'(RADIUS) && yc < (YW'(fw_q) + YW'(RADIUS));
    slot_t = TW'(out_slot_q) + TW'(win_i_q) + TW'(RADIUS + 2);
    if (slot_t >= TW'(2*Ring)) begin
      rslot = SW'(slot_t - TW'(2*Ring));
    end else if (slot_t >= TW'(Ring)) begin
      rslot = SW'(slot_t - TW'(Ring));
    end else begin
      rslot = SW'(slot_t);
    end
    raddr = AW'(rslot) * AW'(MAX_WIDTH) + AW'(CW'(yc - YW'(RADIUS)));
    tr = (win_i_q >= IW'(RADIUS)) ? IW'(win_i_q - IW'(RADIUS)) : IW'(IW'(RADIUS) - win_i_q);
    tc = (win_j_q >= IW'(RADIUS)) ? IW'(win_j_q - IW'(RADIUS)) : IW'(IW'(RADIUS) - win_j_q);
    row_last = win_j_q == IW'(Win - 1);
    win_last = row_last && win_i_q == IW'(Win - 1);
  end

  // fsm next state
  logic out_free;
  logic s1_vld_q, s2_vld_q, s1_last_q, s2_last_q, s3_last_q, s4_last_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc && res_ready) state_d = ST_ROW;
      ST_ROW:   state_d = ST_CALC;
      ST_CALC:  if (win_last) state_d = ST_FLUSH;
                else if (row_last) state_d = ST_ROW;
      ST_FLUSH: if (s4_last_q) state_d = ST_EMIT;
      ST_EMIT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // fsm outputs
  logic issue, load_out, clear_acc;

  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    load_out      = 1'b0;
    tap_idx       = 3'(tc);
    unique case (state_q)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_ROW:   tap_idx = 3'(tr);
      ST_CALC:  issue = 1'b1;
      ST_FLUSH: ;
      ST_EMIT:  load_out = out_free;
      default:  ;
    endcase
  end

  assign clear_acc = in_acc && res_ready;
  assign tap_rd    = tap_q[tap_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // pipeline control
  logic [TAP_W-1:0] row_tap_q, col_tap_q;
  logic [2*TAP_W-1:0] weight_q;
  logic [23:0]      pix_q, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s2_last_q <= 1'b0;
      s3_last_q <= 1'b0;
      s4_last_q <= 1'b0;
    end else begin
      s1_vld_q  <= issue && row_ok && col_ok;
      s2_vld_q  <= s1_vld_q;
      s1_last_q <= issue && win_last;
      s2_last_q <= s1_last_q;
      s3_last_q <= s2_last_q;
      s4_last_q <= s3_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROW) begin
      row_tap_q <= tap_rd;
    end
    col_tap_q <= tap_rd;
    weight_q  <= (2*TAP_W)'(row_tap_q) * (2*TAP_W)'(col_tap_q);
    pix_q     <= ram_rdata;
  end

  // frame counters
  logic out_col_wrap, out_frame_end;

  assign out_col_wrap  = ((CW+1)'(out_col_q) + (CW+1)'(1)) >= (CW+1)'(fw_q);
  assign out_frame_end = out_col_wrap && ((17'(out_row_q) + 17'd1) >= 17'(fh_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      done_q     <= 1'b0;
      fw_q       <= '0;
      fh_q       <= '0;
      lag_q      <= '0;
      pend_q     <= '0;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      win_i_q    <= '0;
      win_j_q    <= '0;
    end else begin
      if (in_acc && is_pix) begin
        active_q <= 1'b1;
        fw_q     <= fw_e;
        fh_q     <= fh_e;
        lag_q    <= lag_e;
        pend_q   <= pend_n;
        done_q   <= row_end;
        if (start) begin
          out_col_q  <= '0;
          out_row_q  <= '0;
          out_slot_q <= '0;
        end
        if (col_wrap) begin
          in_col_q  <= '0;
          in_row_q  <= row_b + 16'd1;
          in_slot_q <= (slot_b == SW'(Ring - 1)) ? '0 : slot_b + SW'(1);
        end else begin
          in_col_q  <= col_b + CW'(1);
          in_row_q  <= row_b;
          in_slot_q <= slot_b;
        end
      end
      if (clear_acc) begin
        win_i_q <= '0;
        win_j_q <= '0;
      end else if (issue) begin
        if (row_last) begin
          win_j_q <= '0;
          win_i_q <= win_i_q + IW'(1);
        end else begin
          win_j_q <= win_j_q + IW'(1);
        end
      end
      if (load_out) begin
        if (out_frame_end) begin
          active_q   <= 1'b0;
          done_q     <= 1'b0;
          pend_q     <= '0;
          in_col_q   <= '0;
          in_row_q   <= '0;
          in_slot_q  <= '0;
          out_col_q  <= '0;
          out_row_q  <= '0;
          out_slot_q <= '0;
        end else begin
          pend_q <= pend_q - PW'(1);
          if (out_col_wrap) begin
            out_col_q  <= '0;
            out_row_q  <= out_row_q + 16'd1;
            out_slot_q <= (out_slot_q == SW'(Ring - 1)) ? '0 : out_slot_q + SW'(1);
          end else begin
            out_col_q <= out_col_q + CW'(1);
          end
        end
      end
    end
  end

  // line store
  gbs_ram #(
    .Width (24),
    .Depth (Ring*MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && is_pix),
    .waddr_i (AW'(slot_b) * AW'(MAX_WIDTH) + AW'(col_b)),
    .wdata_i (s_axis_tdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // color lanes
  gbs_lane_ctrl_t            lane_ctrl;
  logic [NUM_LANES*AccW-1:0] lane_acc;

  assign lane_ctrl.clear = clear_acc;
  assign lane_ctrl.valid = s2_vld_q;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    gbs_lane #(
      .AccW (AccW)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .weight_i (weight_q),
      .pix_i    (pix_q[l*PIX_W +: PIX_W]),
      .acc_o    (lane_acc[l*AccW +: AccW])
    );
  end

  gbs_merge #(
    .AccW (AccW)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load_out),
    .last_i  (out_frame_end),
    .acc_i   (lane_acc),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

  // checks
  `GBS_ASSERT_NEXT(a_flush_to_emit, clk_i, rst_ni,
    state_q == ST_FLUSH && s4_last_q, state_q == ST_EMIT)
  `GBS_ASSERT_NOW(a_no_accept_in_sweep, clk_i, rst_ni,
    state_q == ST_CALC || state_q == ST_ROW, !s_axis_tready)
  `GBS_ASSERT_NEXT(a_frame_end_closes, clk_i, rst_ni,
    load_out && out_frame_end, !active_q && m_axis_tvalid && m_axis_tlast)
  `GBS_ASSERT_NOW(a_pend_bound, clk_i, rst_ni,
    active_q && !done_q, (PW+1)'(pend_q) <= (PW+1)'(lag_q) + (PW+1)'(1))

endmodule

[dv/gaussian_blur_stencil_tb.sv]
// self-checking testbench for the gaussian blur stencil: stream in, stream out, config channel
// depends on gbs_pkg and the gaussian_blur_stencil top level
`timescale 1ns / 1ps

module gaussian_blur_stencil_tb
  import gbs_pkg::*;
();

  localparam int RING_ROWS = 2 * DEF_RADIUS + 2;
  localparam int STALL_LIMIT = 8000;
  localparam int SETTLE_CYCLES = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd200;

  typedef struct {
    logic [23:0] rgb;
    logic        last;
  } blurred_px_t;

  class blur_scoreboard;
    int unsigned errors;
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [15:0] tap [NUM_TAPS];
    logic [23:0] rows [RING_ROWS][DEF_MAX_WIDTH];
    int unsigned in_row, in_col, out_row, out_col, frame_w, frame_h;
    bit active, done;
    blurred_px_t expected [$];

    function new();
      width_reg = RST_IMAGE_WIDTH;
      height_reg = RST_IMAGE_HEIGHT;
      foreach (tap[i]) tap[i] = RST_TAP[i];
      errors = 0;
      active = 0;
      done = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_IMAGE_WIDTH) width_reg = data[10:0];
      else if (idx == CFG_IMAGE_HEIGHT) height_reg = data;
      else if (idx >= CFG_TAP_FIRST && idx <= CFG_TAP_LAST) tap[idx - CFG_TAP_FIRST] = data;
    endfunction

    function bit flush_owed();
      return active && done;
    endfunction

    function int unsigned pending();
      return expected.size();
    endfunction

    function logic [7:0] blur_lane(int unsigned r, int unsigned c, int lane);
      longint unsigned acc;
      int x, y;
      acc = 0;
      for (int dr = -DEF_RADIUS; dr <= DEF_RADIUS; dr++) begin
        x = int'(r) + dr;
        if (x < 0 || x >= int'(frame_h)) continue;
        for (int dc = -DEF_RADIUS; dc <= DEF_RADIUS; dc++) begin
          y = int'(c) + dc;
          if (y < 0 || y >= int'(frame_w)) continue;
          acc += longint'(tap[dr < 0 ? -dr : dr]) * longint'(tap[dc < 0 ? -dc : dc]) *
                 longint'(rows[x % RING_ROWS][y][lane*8 +: 8]);
        end
      end
      acc = acc >> 32;
      return acc > 255 ? 8'd255 : acc[7:0];
    endfunction

    function void note_input(bit cmd, logic [23:0] d);
      bit ready;
      blurred_px_t e;
      longint unsigned n, k;
      ready = 0;
      if (cmd == CMD_PIXEL) begin
        if (!active || done) begin
          frame_w = width_reg == 0 ? 1 : (width_reg > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : width_reg);
          frame_h = height_reg == 0 ? 1 : height_reg;
          in_row = 0; in_col = 0; out_row = 0; out_col = 0;
          active = 1;
          done = 0;
        end
        rows[in_row % RING_ROWS][in_col] = d;
        in_col++;
        if (in_col >= frame_w) begin
          in_col = 0;
          in_row++;
          if (in_row >= frame_h) done = 1;
        end
        if (done) ready = 1;
        else begin
          n = longint'(in_row) * frame_w + in_col;
          k = longint'(out_row) * frame_w + out_col;
          ready = k + DEF_RADIUS * frame_w + DEF_RADIUS < n;
        end
      end else begin
        ready = active && done;
      end
      if (!ready) return;
      for (int l = 0; l < NUM_LANES; l++) e.rgb[l*8 +: 8] = blur_lane(out_row, out_col, l);
      e.last = 0;
      out_col++;
      if (out_col >= frame_w) begin
        out_col = 0;
        out_row++;
        if (out_row >= frame_h) begin
          e.last = 1;
          active = 0;
          done = 0;
        end
      end
      expected.push_back(e);
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns: %s", $realtime, msg);
    endtask

    task check_result(logic [23:0] d, logic last);
      blurred_px_t e;
      if (expected.size() == 0) begin
        report($sformatf("unexpected pixel rgb %h", d));
        return;
      end
      e = expected.pop_front();
      for (int l = 0; l < NUM_LANES; l++)
        if (d[l*8 +: 8] !== e.rgb[l*8 +: 8])
          report($sformatf("lane %0d got %h want %h", l, d[l*8 +: 8], e.rgb[l*8 +: 8]));
      if (last !== e.last) report($sformatf("frame end got %b want %b", last, e.last));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  blur_scoreboard sb = new();
  int unsigned pixels_sent = 0;
  int unsigned quiet_cycles = 0;
  bit sender_busy = 1'b0;
  bit sink_steady = 1'b0;
  int unsigned hold_len = 0;

  gaussian_blur_stencil uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
      if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver: random stalls, quiet stretches, and one long hold-off on request
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_len != 0) begin
        m_axis_tready = 1'b0;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
      end else begin
        gap = sink_steady ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
          m_axis_tready = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // all driving tasks start and end at a falling edge
  task automatic send_item(bit cmd, logic [23:0] rgb);
    int unsigned gap;
    gap = sender_busy ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = cmd;
    s_axis_tdata = rgb;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
    if (cmd == CMD_PIXEL) pixels_sent++;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    s_axis_tvalid = 1'b0;
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_taps(logic [15:0] base, int unsigned spread);
    for (int i = 0; i < NUM_TAPS; i++)
      cfg_write(CFG_IDX_W'(CFG_TAP_FIRST + i), CFG_DATA_W'(base + $urandom_range(0, spread)));
  endtask

  task automatic flush_frame();
    while (sb.flush_owed()) send_item(CMD_DRAIN, 24'($urandom));
  endtask

  // a frame of random pixels with some drain noise; sometimes the flush is cut short
  task automatic random_frame(int unsigned w, int unsigned h);
    cfg_write(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    cfg_write(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(CMD_DRAIN, 24'($urandom));
      send_item(CMD_PIXEL, 24'($urandom));
    end
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(0, 3)) if (sb.flush_owed()) send_item(CMD_DRAIN, '0);
      send_item(CMD_PIXEL, 24'($urandom));
    end
    flush_frame();
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: drain with nothing pending, saturating taps, field extremes
    send_item(CMD_DRAIN, 24'hffffff);
    cfg_write(CFG_UNUSED, 16'hffff);
    set_taps(16'hffff, 0);
    cfg_write(CFG_IMAGE_WIDTH, 16'd4);
    cfg_write(CFG_IMAGE_HEIGHT, 16'd3);
    for (int i = 0; i < 12; i++) begin
      send_item(CMD_PIXEL, i[0] ? 24'hffffff : 24'h000000);
      if (i == 5) send_item(CMD_DRAIN, 24'h000000);
    end
    flush_frame();
    send_item(CMD_DRAIN, 24'h0);
    wait_idle();
    set_taps(16'h0000, 0);
    cfg_write(CFG_IMAGE_WIDTH, 16'd0);
    cfg_write(CFG_IMAGE_HEIGHT, 16'd0);
    send_item(CMD_PIXEL, 24'hffffff);
    send_item(CMD_PIXEL, 24'h808080);
    wait_idle();
    set_taps(16'd5900, 100);
    cfg_write(CFG_IMAGE_WIDTH, 16'd3);
    cfg_write(CFG_IMAGE_HEIGHT, 16'd2);
    send_item(CMD_PIXEL, 24'h0000ff);
    send_item(CMD_PIXEL, 24'h00ff00);
    send_item(CMD_PIXEL, 24'hff0000);
    flush_frame();
    wait_idle();

    // pressure: long receiver hold-off while the sender keeps offering
    sender_busy = 1'b1;
    hold_len = 1500;
    random_frame(8, 8);
    sender_busy = 1'b0;

    while (pixels_sent < 500) begin
      case ($urandom_range(0, 3))
        0: set_taps(16'($urandom_range(0, 65535)), $urandom_range(0, 65535));
        1: set_taps(16'd5000, 2000);
        default: set_taps(16'd2000, 12000);
      endcase
      sink_steady = $urandom_range(0, 3) == 0;
      sender_busy = $urandom_range(0, 3) == 0;
      random_frame($urandom_range(1, 12), $urandom_range(1, 8));
    end
    sink_steady = 1'b0;
    sender_busy = 1'b0;

    // widest row, width register at its top value: one full row, flush left to the next frame
    set_taps(16'd5900, 100);
    cfg_write(CFG_IMAGE_WIDTH, 16'd2047);
    cfg_write(CFG_IMAGE_HEIGHT, 16'd1);
    repeat (DEF_MAX_WIDTH) send_item(CMD_PIXEL, 24'($urandom));
    wait_idle();

    // tallest frame: never completes, results flow once the lag is reached
    cfg_write(CFG_IMAGE_WIDTH, 16'd1);
    cfg_write(CFG_IMAGE_HEIGHT, 16'hffff);
    repeat (40) send_item($urandom_range(0, 5) == 0, 24'($urandom));
    wait_idle();

    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
